FILE: hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by bitstream_header_parser.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while reset is released
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: hw/rtl/bhp_pkg.sv
// types and constants of the bitstream header parser
package bhp_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_TYPE    = 3'd1,
    PH_STRLEN  = 3'd2,
    PH_STRING  = 3'd3,
    PH_BITLEN  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    CLS_MAGIC   = 3'd0,
    CLS_TYPE    = 3'd1,
    CLS_STRLEN  = 3'd2,
    CLS_STRING  = 3'd3,
    CLS_BITLEN  = 3'd4,
    CLS_PAYLOAD = 3'd5,
    CLS_IGNORED = 3'd6,
    CLS_UNKNOWN = 3'd7
  } byte_class_t;

  typedef logic [1:0] field_tag_t;

  localparam logic [3:0] MAGIC_LEN = 4'd13;

  localparam logic [7:0] MAGIC_BYTES [13] = '{
    8'h00, 8'h09, 8'h0F, 8'hF0, 8'h0F, 8'hF0, 8'h0F, 8'hF0,
    8'h0F, 8'hF0, 8'h00, 8'h00, 8'h01
  };

  localparam logic [7:0] TYPE_A = 8'h61;
  localparam logic [7:0] TYPE_D = 8'h64;
  localparam logic [7:0] TYPE_E = 8'h65;

endpackage

FILE: hw/rtl/bhp_in_if.sv
// byte input channel of the bitstream header parser
interface bhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

FILE: hw/rtl/bhp_out_if.sv
// classified byte result channel of the bitstream header parser
interface bhp_out_if;
  logic                 valid;
  logic                 ready;
  bhp_pkg::byte_class_t byte_class;
  bhp_pkg::field_tag_t  field_tag;
  logic [7:0]           out_byte;
  logic                 last_of_field;
  logic                 magic_error;
  logic                 header_done;
  logic [31:0]          bitstream_length;

  modport source (
    output valid, output byte_class, output field_tag, output out_byte,
    output last_of_field, output magic_error, output header_done,
    output bitstream_length, input ready
  );
  modport sink (
    input valid, input byte_class, input field_tag, input out_byte,
    input last_of_field, input magic_error, input header_done,
    input bitstream_length, output ready
  );
endinterface

FILE: hw/rtl/bitstream_header_parser.sv
// bitstream header parser: classifies each byte of a configuration file
//
//   channel   dir   payload                                   handshake
//   in_bus    in    in_byte                                   valid/ready
//   out_bus   out   byte_class, field_tag, out_byte,          valid/ready
//                   last_of_field, magic_error, header_done,
//                   bitstream_length
//
// one byte per cycle unless out_bus stalls; a byte passes the input and result stages
// the parse state and the result are computed in one pass from the input stage register
// in_bus.ready is high whenever the input stage is empty or moves forward this cycle
// while a result is held at out_bus one more byte waits in the input stage
// rst_n is synchronous and clears the parse state and both stage valids
`include "assert_macros.svh"

module bitstream_header_parser (
  input  logic       clk,
  input  logic       rst_n,
  bhp_in_if.sink     in_bus,
  bhp_out_if.source  out_bus
);

  // input stage
  logic       in_v_r;
  logic [7:0] in_byte_r;

  // parse state
  bhp_pkg::phase_t     phase_r, phase_nxt;
  logic [3:0]          magic_index_r, magic_index_nxt;
  logic                mismatch_r, mismatch_nxt;
  bhp_pkg::field_tag_t cur_tag_r, cur_tag_nxt;
  logic [1:0]          len_cnt_r, len_cnt_nxt;
  logic [31:0]         len_acc_r, len_acc_nxt;
  logic [31:0]         remain_r, remain_nxt;
  logic [31:0]         stored_len_r, stored_len_nxt;
  logic                header_r, header_nxt;

  // result stage
  logic                 out_v_r;
  bhp_pkg::byte_class_t cls_r;
  bhp_pkg::field_tag_t  tag_r;
  logic [7:0]           out_byte_r;
  logic                 last_r;

  bhp_pkg::byte_class_t cls;
  bhp_pkg::field_tag_t  tag;
  logic                 last;
  logic                 move;
  logic                 in_ready;

  assign move     = in_v_r && (!out_v_r || out_bus.ready);
  assign in_ready = !in_v_r || move;
  assign in_bus.ready = in_ready;

  always_comb begin
    phase_nxt       = phase_r;
    magic_index_nxt = magic_index_r;
    mismatch_nxt    = mismatch_r;
    cur_tag_nxt     = cur_tag_r;
    len_cnt_nxt     = len_cnt_r;
    len_acc_nxt     = len_acc_r;
    remain_nxt      = remain_r;
    stored_len_nxt  = stored_len_r;
    header_nxt      = header_r;
    cls             = bhp_pkg::CLS_IGNORED;
    tag             = '0;
    last            = 1'b0;
    case (phase_r)
      bhp_pkg::PH_MAGIC: begin
        cls = bhp_pkg::CLS_MAGIC;
        if (in_byte_r != bhp_pkg::MAGIC_BYTES[magic_index_r]) begin
          mismatch_nxt = 1'b1;
        end
        magic_index_nxt = magic_index_r + 4'd1;
        if (magic_index_nxt == bhp_pkg::MAGIC_LEN) begin
          phase_nxt = bhp_pkg::PH_TYPE;
        end
      end
      bhp_pkg::PH_TYPE: begin
        if (in_byte_r >= bhp_pkg::TYPE_A && in_byte_r <= bhp_pkg::TYPE_D) begin
          cls         = bhp_pkg::CLS_TYPE;
          cur_tag_nxt = in_byte_r[1:0] - 2'd1;
          tag         = cur_tag_nxt;
          len_cnt_nxt = '0;
          len_acc_nxt = '0;
          phase_nxt   = bhp_pkg::PH_STRLEN;
        end else if (in_byte_r == bhp_pkg::TYPE_E) begin
          cls         = bhp_pkg::CLS_TYPE;
          len_cnt_nxt = '0;
          len_acc_nxt = '0;
          phase_nxt   = bhp_pkg::PH_BITLEN;
        end else begin
          cls = bhp_pkg::CLS_UNKNOWN;
        end
      end
      bhp_pkg::PH_STRLEN: begin
        cls         = bhp_pkg::CLS_STRLEN;
        tag         = cur_tag_r;
        // string length is 16 bits big-endian
        len_acc_nxt = {16'h0000, len_acc_r[7:0], in_byte_r};
        len_cnt_nxt = len_cnt_r + 2'd1;
        if (len_cnt_r == 2'd1) begin
          len_cnt_nxt = '0;
          remain_nxt  = len_acc_nxt;
          phase_nxt   = (len_acc_nxt == 32'd0) ? bhp_pkg::PH_TYPE : bhp_pkg::PH_STRING;
        end
      end
      bhp_pkg::PH_STRING: begin
        cls = bhp_pkg::CLS_STRING;
        tag = cur_tag_r;
        if (remain_r <= 32'd1) begin
          last       = 1'b1;
          remain_nxt = '0;
          phase_nxt  = bhp_pkg::PH_TYPE;
        end else begin
          remain_nxt = remain_r - 32'd1;
        end
      end
      bhp_pkg::PH_BITLEN: begin
        cls         = bhp_pkg::CLS_BITLEN;
        len_acc_nxt = {len_acc_r[23:0], in_byte_r};
        len_cnt_nxt = len_cnt_r + 2'd1;
        if (len_cnt_r == 2'd3) begin
          stored_len_nxt = len_acc_nxt;
          remain_nxt     = len_acc_nxt;
          header_nxt     = 1'b1;
          phase_nxt      = (len_acc_nxt == 32'd0) ? bhp_pkg::PH_DONE : bhp_pkg::PH_PAYLOAD;
        end
      end
      bhp_pkg::PH_PAYLOAD: begin
        cls = bhp_pkg::CLS_PAYLOAD;
        if (remain_r <= 32'd1) begin
          last       = 1'b1;
          remain_nxt = '0;
          phase_nxt  = bhp_pkg::PH_DONE;
        end else begin
          remain_nxt = remain_r - 32'd1;
        end
      end
      default: begin
        cls = bhp_pkg::CLS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      phase_r       <= bhp_pkg::PH_MAGIC;
      magic_index_r <= '0;
      mismatch_r    <= 1'b0;
      cur_tag_r     <= '0;
      len_cnt_r     <= '0;
      len_acc_r     <= '0;
      remain_r      <= '0;
      stored_len_r  <= '0;
      header_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_bus.valid;
      end
      if (move) begin
        out_v_r       <= 1'b1;
        phase_r       <= phase_nxt;
        magic_index_r <= magic_index_nxt;
        mismatch_r    <= mismatch_nxt;
        cur_tag_r     <= cur_tag_nxt;
        len_cnt_r     <= len_cnt_nxt;
        len_acc_r     <= len_acc_nxt;
        remain_r      <= remain_nxt;
        stored_len_r  <= stored_len_nxt;
        header_r      <= header_nxt;
      end else if (out_bus.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_bus.valid) begin
      in_byte_r <= in_bus.in_byte;
    end
    if (move) begin
      cls_r      <= cls;
      tag_r      <= tag;
      out_byte_r <= in_byte_r;
      last_r     <= last;
    end
  end

  assign out_bus.valid            = out_v_r;
  assign out_bus.byte_class       = cls_r;
  assign out_bus.field_tag        = tag_r;
  assign out_bus.out_byte         = out_byte_r;
  assign out_bus.last_of_field    = last_r;
  // flags and length are taken from the state the result left behind
  assign out_bus.magic_error      = mismatch_r;
  assign out_bus.header_done      = header_r;
  assign out_bus.bitstream_length = stored_len_r;

  `ASSERT_RST(a_header_sticky, clk, rst_n, !$fell(header_r), "header flag dropped")
  `ASSERT_RST(a_mismatch_sticky, clk, rst_n, !$fell(mismatch_r), "magic error dropped")
  `ASSERT_RST(a_magic_index_range, clk, rst_n,
    (phase_r == bhp_pkg::PH_MAGIC) |-> (magic_index_r < bhp_pkg::MAGIC_LEN),
    "magic index past prefix")
  `ASSERT_RST(a_payload_needs_header, clk, rst_n,
    (phase_r == bhp_pkg::PH_PAYLOAD || phase_r == bhp_pkg::PH_DONE) |-> header_r,
    "payload phase before header complete")
  `ASSERT_RST(a_full_blocks_input, clk, rst_n,
    (in_v_r && out_v_r && !out_bus.ready) |-> !in_bus.ready,
    "input taken with both stages full")

endmodule
